// ----- rtl/yrds_pkg.sv -----
// constants, register indexes and the byte, size and step clamps for the yuv to rgb decimating scaler
// no dependencies
package yrds_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = 13;   // holds 0..MAX_DIM
  localparam int unsigned POS_W     = 12;   // holds 0..MAX_DIM-1
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned STEP_MAX  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUM_W     = 26;

  // q2.14 coefficients
  localparam logic signed [SUM_W-1:0] C_RV = 26'sd22458;
  localparam logic signed [SUM_W-1:0] C_GV = 26'sd11436;
  localparam logic signed [SUM_W-1:0] C_GU = 26'sd5532;
  localparam logic signed [SUM_W-1:0] C_BU = 26'sd28384;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1280;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd720;
  localparam logic [STEP_W-1:0] RST_STEP_X       = 5'd5;
  localparam logic [STEP_W-1:0] RST_STEP_Y       = 5'd5;
  localparam logic [DIM_W-1:0]  RST_OUT_WIDTH    = 13'd256;
  localparam logic [DIM_W-1:0]  RST_OUT_HEIGHT   = 13'd144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_STEP_X       = 3'd2,
    REG_STEP_Y       = 3'd3,
    REG_OUT_WIDTH    = 3'd4,
    REG_OUT_HEIGHT   = 3'd5
  } reg_index_t;

  // negative gives 0, quotient above 255 gives 255
  function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (sum[SUM_W-2:22] != '0) begin
      res = 8'hff;
    end else begin
      res = sum[21:14];
    end
    return res;
  endfunction

  // 0 acts as 1 unless zero_ok is set, above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic zero_ok);
    logic [DIM_W-1:0] res;
    if (v == '0 && !zero_ok) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
    logic [STEP_W-1:0] res;
    if (v == '0) begin
      res = STEP_W'(1);
    end else if (v > STEP_W'(STEP_MAX)) begin
      res = STEP_W'(STEP_MAX);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- rtl/yuv_to_rgb_decimating_scaler_top.sv -----
// yuv to rgb conversion with nearest neighbor downscale: grid counters, color math, output
// depends on yrds_pkg
// an accepted pixel is registered in stage 1, then in the output register as its rgb word
// throughput: one pixel per cycle under no rgb stall; off-grid pixels take no output slot
// sync reset (rst high): registers return to their defaults, counters and stages clear
// config words are taken every cycle (cfg_ready stays high)
module yuv_to_rgb_decimating_scaler_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yrds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrds_pkg::DIM_W-1:0]       cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  logic [7:0]                       luma,
  input  logic [7:0]                       chroma_u,
  input  logic [7:0]                       chroma_v,
  output logic                             rgb_valid,
  input  logic                             rgb_stall,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  output logic                             frame_end
);
  import yrds_pkg::*;

  // config registers
  logic [DIM_W-1:0]  frame_width, frame_height, out_width, out_height;
  logic [STEP_W-1:0] step_x, step_y;

  // grid counters
  logic [POS_W-1:0]   src_column, src_row;
  logic [PHASE_W-1:0] phase_x, phase_y;
  logic [DIM_W-1:0]   kept_column, kept_row;

  // stage 1: captured pixel
  logic       s1_valid, s1_last;
  logic [7:0] s1_y, s1_u, s1_v;

  logic [DIM_W-1:0]  fw, fh, ow, oh;
  logic [STEP_W-1:0] sx, sy;
  logic              pix_acc, s2_ready, s1_ready;
  logic              on_grid, keep, last_col, last_row, row_end, frame_done;
  logic [DIM_W:0]    col_plus_step, row_plus_step, kcol_inc, krow_inc;
  logic [DIM_W-1:0]  src_col_inc, src_row_inc;
  logic [STEP_W-1:0] phx_inc, phy_inc;

  logic signed [8:0]       d_s, e_s;
  logic signed [SUM_W-1:0] base, r_sum, g_sum, b_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      step_x       <= RST_STEP_X;
      step_y       <= RST_STEP_Y;
      out_width    <= RST_OUT_WIDTH;
      out_height   <= RST_OUT_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_STEP_X:       step_x       <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:       step_y       <= cfg_data[STEP_W-1:0];
        REG_OUT_WIDTH:    out_width    <= cfg_data;
        REG_OUT_HEIGHT:   out_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fw = clamp_dim(frame_width, 1'b0);
  assign fh = clamp_dim(frame_height, 1'b0);
  assign ow = clamp_dim(out_width, 1'b1);
  assign oh = clamp_dim(out_height, 1'b1);
  assign sx = clamp_step(step_x);
  assign sy = clamp_step(step_y);

  // handshake: output register frees when empty or taken
  assign s2_ready  = !rgb_valid || !rgb_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pix_stall = !s1_ready;
  assign pix_acc   = pix_valid && !pix_stall;

  // grid decision for the current pixel
  assign on_grid = (phase_x == '0) && (phase_y == '0);
  assign keep    = on_grid && (kept_column < ow) && (kept_row < oh);

  assign kcol_inc      = {1'b0, kept_column} + (DIM_W+1)'(1);
  assign krow_inc      = {1'b0, kept_row} + (DIM_W+1)'(1);
  assign col_plus_step = (DIM_W+1)'(src_column) + (DIM_W+1)'(sx);
  assign row_plus_step = (DIM_W+1)'(src_row) + (DIM_W+1)'(sy);
  assign last_col      = (kcol_inc >= {1'b0, ow}) || (col_plus_step >= {1'b0, fw});
  assign last_row      = (krow_inc >= {1'b0, oh}) || (row_plus_step >= {1'b0, fh});

  assign src_col_inc = {1'b0, src_column} + DIM_W'(1);
  assign src_row_inc = {1'b0, src_row} + DIM_W'(1);
  assign phx_inc     = {1'b0, phase_x} + STEP_W'(1);
  assign phy_inc     = {1'b0, phase_y} + STEP_W'(1);
  assign row_end     = src_col_inc >= fw;
  assign frame_done  = src_row_inc >= fh;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_column  <= '0;
      src_row     <= '0;
      phase_x     <= '0;
      phase_y     <= '0;
      kept_column <= '0;
      kept_row    <= '0;
    end else if (pix_acc) begin
      if (!row_end) begin
        src_column <= src_col_inc[POS_W-1:0];
        phase_x    <= (phx_inc >= sx) ? '0 : phx_inc[PHASE_W-1:0];
        if (on_grid && kept_column < ow) begin
          kept_column <= kcol_inc[DIM_W-1:0];
        end
      end else begin
        src_column  <= '0;
        phase_x     <= '0;
        kept_column <= '0;
        if (frame_done) begin
          src_row  <= '0;
          phase_y  <= '0;
          kept_row <= '0;
        end else begin
          if (phase_y == '0 && kept_row < oh) begin
            kept_row <= krow_inc[DIM_W-1:0];
          end
          src_row <= src_row_inc[POS_W-1:0];
          phase_y <= (phy_inc >= sy) ? '0 : phy_inc[PHASE_W-1:0];
        end
      end
    end
  end

  // stage 1: only kept pixels take a slot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pix_acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pix_acc) begin
      s1_y    <= luma;
      s1_u    <= chroma_u;
      s1_v    <= chroma_v;
      s1_last <= last_col && last_row;
    end
  end

  // color math on the captured pixel
  assign d_s   = $signed({1'b0, s1_v}) - 9'sd128;
  assign e_s   = $signed({1'b0, s1_u}) - 9'sd128;
  assign base  = $signed({4'b0, s1_y, 14'b0});
  assign r_sum = base + C_RV * SUM_W'(d_s);
  assign g_sum = base - C_GV * SUM_W'(d_s) - C_GU * SUM_W'(e_s);
  assign b_sum = base + C_BU * SUM_W'(e_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (s2_ready) begin
      rgb_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      red       <= to_byte(r_sum);
      green     <= to_byte(g_sum);
      blue      <= to_byte(b_sum);
      frame_end <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // a pixel off the grid never reaches the first stage
  a_drop_off_grid: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && !on_grid) |=> !s1_valid)
    else $error("off-grid pixel entered the pipeline");

  // a blocked first stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_y) && $stable(s1_last)))
    else $error("first stage lost a word under stall");

  // kept counters never pass the largest output size
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (kept_column <= DIM_W'(MAX_DIM)) && (kept_row <= DIM_W'(MAX_DIM)))
    else $error("kept counter out of range");
`endif

endmodule

// ----- test/yuv_to_rgb_decimating_scaler_top_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for yuv_to_rgb_decimating_scaler_top: a directed table, then random
// frames under several register settings, all words checked against typed values or a built-in predictor
// depends on yrds_pkg and the block's rtl
module yuv_to_rgb_decimating_scaler_top_tb;
  import yrds_pkg::*;

  localparam int unsigned PIPE_LATENCY     = 2;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned NUM_PHASES       = 12;
  localparam int unsigned PIXELS_PER_PHASE = 136;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register lives here

  // q2.14 conversion coefficients
  localparam int K_RV = 22458;
  localparam int K_GV = 11436;
  localparam int K_GU = 5532;
  localparam int K_BU = 28384;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_word_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    logic [7:0]           y;
    logic [7:0]           u;
    logic [7:0]           v;
    bit                   typed;
    rgb_word_t            want;
  } script_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [7:0]           luma      = '0;
  logic [7:0]           chroma_u  = '0;
  logic [7:0]           chroma_v  = '0;
  logic                 rgb_valid;
  logic                 rgb_stall = 1'b0;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic                 frame_end;

  yuv_to_rgb_decimating_scaler_top uut (.*);

  // predictor copy of the registers and the grid counters
  logic [DIM_W-1:0]  frame_w_reg = RST_FRAME_WIDTH;
  logic [DIM_W-1:0]  frame_h_reg = RST_FRAME_HEIGHT;
  logic [STEP_W-1:0] step_x_reg  = RST_STEP_X;
  logic [STEP_W-1:0] step_y_reg  = RST_STEP_Y;
  logic [DIM_W-1:0]  out_w_reg   = RST_OUT_WIDTH;
  logic [DIM_W-1:0]  out_h_reg   = RST_OUT_HEIGHT;
  int unsigned col_pos = 0, row_pos = 0, col_phase = 0, row_phase = 0;
  int unsigned cols_kept = 0, rows_kept = 0;

  rgb_word_t   pending_rgb[$];
  script_row_t script[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  idle_mode_t  idle_mode   = IDLE_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clip(int unsigned val, int unsigned lo, int unsigned hi);
    if (val < lo) return lo;
    if (val > hi) return hi;
    return val;
  endfunction

  function automatic logic [7:0] channel_byte(int sum);
    if (sum < 0) return 8'd0;
    if ((sum >>> 14) > 255) return 8'hff;
    return 8'(sum >>> 14);
  endfunction

  // converts one accepted pixel and advances the grid; returns 1 when a word is due
  function automatic bit convert_and_advance(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, output rgb_word_t w);
    int unsigned fw, fh, sx, sy, ow, oh;
    int base, cb, cr;
    bit keep, last_col, last_row;
    fw = clip(32'(frame_w_reg), 1, MAX_DIM);
    fh = clip(32'(frame_h_reg), 1, MAX_DIM);
    sx = clip(32'(step_x_reg), 1, STEP_MAX);
    sy = clip(32'(step_y_reg), 1, STEP_MAX);
    ow = clip(32'(out_w_reg), 0, MAX_DIM);
    oh = clip(32'(out_h_reg), 0, MAX_DIM);
    w = '0;
    keep = col_phase == 0 && row_phase == 0 && cols_kept < ow && rows_kept < oh;
    if (keep) begin
      base = int'(y) * 16384;
      cb = int'(u) - 128;
      cr = int'(v) - 128;
      last_col = cols_kept + 1 >= ow || col_pos + sx >= fw;
      last_row = rows_kept + 1 >= oh || row_pos + sy >= fh;
      w.red       = channel_byte(base + K_RV * cr);
      w.green     = channel_byte(base - K_GV * cr - K_GU * cb);
      w.blue      = channel_byte(base + K_BU * cb);
      w.frame_end = last_col && last_row;
    end
    if (col_phase == 0 && row_phase == 0 && cols_kept < ow) cols_kept++;
    if (col_pos + 1 < fw) begin
      col_pos++;
      col_phase = (col_phase + 1 >= sx) ? 0 : col_phase + 1;
    end else begin
      col_pos   = 0;
      col_phase = 0;
      cols_kept = 0;
      if (row_pos + 1 >= fh) begin
        row_pos   = 0;
        row_phase = 0;
        rows_kept = 0;
      end else begin
        if (row_phase == 0 && rows_kept < oh) rows_kept++;
        row_pos++;
        row_phase = (row_phase + 1 >= sy) ? 0 : row_phase + 1;
      end
    end
    return keep;
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 55;
      IDLE_BOTH:   return $urandom_range(0, 99) < 16;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic send_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v,
                            input bit typed, input rgb_word_t want);
    rgb_word_t w;
    while (sender_idles()) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    luma      <= y;
    chroma_u  <= u;
    chroma_v  <= v;
    do @(posedge clk); while (pix_stall);
    if (convert_and_advance(y, u, v, w)) pending_rgb.push_back(typed ? want : w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  frame_w_reg = data;
      REG_FRAME_HEIGHT: frame_h_reg = data;
      REG_STEP_X:       step_x_reg  = data[STEP_W-1:0];
      REG_STEP_Y:       step_y_reg  = data[STEP_W-1:0];
      REG_OUT_WIDTH:    out_w_reg   = data;
      REG_OUT_HEIGHT:   out_h_reg   = data;
      default: ;
    endcase
  endtask

  // dropped pixels leave no word behind, so wait out the pipeline as well
  task automatic drain();
    pix_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: rgb_stall <= $urandom_range(0, 99) < 55;
        IDLE_BOTH:     rgb_stall <= $urandom_range(0, 99) < 16;
        default:       rgb_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_words
    rgb_word_t got, exp;
    if (!rst && rgb_valid && !rgb_stall) begin
      got = '{red, green, blue, frame_end};
      if (pending_rgb.size() == 0) begin
        note_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d end=%0b",
                                got.red, got.green, got.blue, got.frame_end));
      end else begin
        exp = pending_rgb.pop_front();
        if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue ||
            got.frame_end !== exp.frame_end) begin
          note_mismatch($sformatf("expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                                  exp.red, exp.green, exp.blue, exp.frame_end,
                                  got.red, got.green, got.blue, got.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DIM_W-1:0]  fw, fh, ow, oh;
    logic [STEP_W-1:0] sx, sy;
    bit need_drain;
    // first pixel runs on the reset settings; then a 1x1 frame keeps every pixel as
    // its own frame, so the flat-chroma rows can be typed in directly
    script = '{
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd128, 8'd128, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{ROW_CFG, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_STEP_X,       13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_STEP_Y,       13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_OUT_WIDTH,    13'd1,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_OUT_HEIGHT,   13'd1,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_SPARE,        13'h1fff, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd9,   8'd200, 8'd60,  1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd128, 8'd128, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd128, 8'd128, 1'b1,
        '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd77,  8'd128, 8'd128, 1'b1,
        '{8'd77, 8'd77, 8'd77, 1'b1}},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd85,  8'd170, 8'd85,  1'b0, '0},
      // zero output width keeps nothing
      '{ROW_CFG, REG_OUT_WIDTH,    13'd0,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd1,   8'd2,   8'd3,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd200, 8'd100, 8'd50,  1'b0, '0},
      // sizes and steps, some past their range
      '{ROW_CFG, REG_FRAME_WIDTH,  13'h1fff, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 13'd3,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_STEP_X,       13'd31,   8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_STEP_Y,       13'd16,   8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_OUT_WIDTH,    13'h1fff, 8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_CFG, REG_OUT_HEIGHT,   13'd2,    8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd40,  8'd90,  8'd240, 1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd230, 8'd20,  8'd140, 1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd128, 8'd128, 8'd0,   1'b0, '0},
      '{ROW_PIX, REG_FRAME_WIDTH,  13'd0,    8'd16,  8'd255, 8'd128, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    need_drain = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (need_drain) drain();
        need_drain = 1'b0;
        write_reg(script[i].idx, script[i].data);
      end else begin
        cfg_valid <= 1'b0;
        need_drain = 1'b1;
        send_pixel(script[i].y, script[i].u, script[i].v, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          fw = 13'd2; fh = 13'd2; sx = 5'd1; sy = 5'd1;
          ow = DIM_W'(MAX_DIM); oh = DIM_W'(MAX_DIM);
        end
        1: begin
          fw = DIM_W'(MAX_DIM); fh = 13'd2; sx = STEP_W'(STEP_MAX); sy = 5'd1;
          ow = DIM_W'(MAX_DIM); oh = DIM_W'(MAX_DIM);
        end
        2: begin
          fw = 13'h1fff; fh = 13'h1fff; sx = 5'h1f; sy = 5'd0; ow = 13'd3; oh = 13'h1fff;
        end
        default: begin
          fw = DIM_W'($urandom_range(2, 24));
          fh = DIM_W'($urandom_range(2, 10));
          sx = STEP_W'($urandom_range(1, 4));
          sy = STEP_W'($urandom_range(1, 4));
          ow = DIM_W'($urandom_range(1, 10));
          oh = DIM_W'($urandom_range(1, 6));
          if ($urandom_range(0, 5) == 0) sx = STEP_W'($urandom_range(0, 31));
          if ($urandom_range(0, 5) == 0) sy = STEP_W'($urandom_range(0, 31));
          if ($urandom_range(0, 7) == 0) fw = DIM_W'($urandom_range(0, 1));
          if ($urandom_range(0, 9) == 0) ow = '0;
        end
      endcase
      // upper data bits of the step words must be ignored
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_STEP_X, {8'($urandom_range(0, 255)), sx});
      write_reg(REG_STEP_Y, {8'($urandom_range(0, 255)), sy});
      write_reg(REG_OUT_WIDTH, ow);
      write_reg(REG_OUT_HEIGHT, oh);
      cfg_valid <= 1'b0;
      idle_mode = idle_mode_t'(ph % 4);
      repeat (PIXELS_PER_PHASE) send_pixel(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
